[rtl/core/poleu_pkg.sv]
package poleu_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_LOCATE = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } cell_ctl_t;

endpackage

[rtl/core/positional_ordered_list_engine_unit.sv]
// positional ordered list engine: a row of DEPTH cells, one entry per cell
// result: the result word is registered, valid in the cycle after the request is taken
// throughput: one request per cycle; a request is taken while the result register is
// empty or its word is being taken in the same cycle
// reset: synchronous active-low rst_n empties the list and the result register;
// cell contents are not cleared
module positional_ordered_list_engine_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_result_value,
  output logic [7:0]         out_found_position,
  output logic [7:0]         out_list_length
);
  import poleu_pkg::*;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  logic [1:0]         status_r, status_nxt;
  logic signed [31:0] rval_r, rval_nxt;
  logic [7:0]         fpos_r, fpos_nxt;
  logic [7:0]         len_r;

  logic signed [31:0] cell_q [DEPTH];
  cell_ctl_t          cell_ctl [DEPTH];

  logic               accept;
  logic [7:0]         idx;
  logic               ins_pos_ok, rd_pos_ok, full;
  logic               ins_go, del_go;
  logic signed [31:0] rd_val;
  logic               hit;
  logic [7:0]         hit_pos;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign idx        = in_position - 8'd1;
  assign ins_pos_ok = (in_position != 8'd0) &&
                      ({1'b0, in_position} <= (9'(count_r) + 9'd1));
  assign rd_pos_ok  = (in_position != 8'd0) && ({1'b0, in_position} <= 9'(count_r));
  assign full       = (count_r == CNT_W'(DEPTH));
  assign ins_go     = accept && (in_req_type == REQ_INSERT) && ins_pos_ok && !full;
  assign del_go     = accept && (in_req_type == REQ_DELETE) && rd_pos_ok;

  // per-cell shift control: insert shifts right of the slot, delete pulls left
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      cell_ctl[k].load       = ins_go && (idx == 8'(k));
      cell_ctl[k].from_left  = ins_go && (idx < 8'(k));
      cell_ctl[k].from_right = del_go && (idx <= 8'(k));
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_q, right_q;
    if (g == 0) begin : g_first
      assign left_q = in_value;
    end else begin : g_mid
      assign left_q = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_q = cell_q[g];
    end else begin : g_inner
      assign right_q = cell_q[g+1];
    end
    poleu_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[g]),
      .new_val (in_value),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[g])
    );
  end

  // read select and first-match search over the occupied cells
  always_comb begin
    rd_val  = '0;
    hit     = 1'b0;
    hit_pos = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (idx == 8'(k)) begin
        rd_val = cell_q[k];
      end
    end
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if ((CNT_W'(k) < count_r) && (cell_q[k] == in_value)) begin
        hit     = 1'b1;
        hit_pos = 8'(k + 1);
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rval_nxt   = '0;
    fpos_nxt   = '0;
    case (in_req_type)
      REQ_INSERT: begin
        if (!ins_pos_ok) begin
          status_nxt = ST_BADPOS;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          fpos_nxt  = in_position;
        end
      end
      REQ_DELETE, REQ_READ: begin
        if (!rd_pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          rval_nxt = rd_val;
          fpos_nxt = in_position;
          if (in_req_type == REQ_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      REQ_LOCATE: begin
        status_nxt = hit ? ST_OK : ST_NOTFOUND;
        fpos_nxt   = hit_pos;
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rval_r   <= rval_nxt;
      fpos_r   <= fpos_nxt;
      len_r    <= 8'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_result_value   = rval_r;
  assign out_found_position = fpos_r;
  assign out_list_length    = len_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list length beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_go |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_CLEAR) |=> (count_r == '0 && out_list_length == 8'd0))
    else $error("clear left entries");

  a_result_len: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_list_length == 8'(count_r))
    else $error("reported length differs from stored length");
`endif

endmodule

[rtl/core/poleu_cell.sv]
module poleu_cell (
  input  logic                  clk,
  input  poleu_pkg::cell_ctl_t  ctl,
  input  logic signed [31:0]    new_val,
  input  logic signed [31:0]    left_q,
  input  logic signed [31:0]    right_q,
  output logic signed [31:0]    q
);
  import poleu_pkg::*;

  logic signed [31:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= new_val;
    end else if (ctl.from_left) begin
      data_r <= left_q;
    end else if (ctl.from_right) begin
      data_r <= right_q;
    end
  end

  assign q = data_r;

endmodule
